@@ hw/rtl/brtt_pkg.sv @@
// brtt_pkg: shared types, codes and constants of the block request tag tracker
// no dependencies; used by every module of the tracker except brtt_ram, and by its checker

package brtt_pkg;

    // parameter defaults
    localparam int SLOTS_DEF       = 16;
    localparam int HEADS_DEF       = 256;
    localparam int MAX_SECTORS_DEF = 8;

    // fixed field widths
    localparam int LBA_W      = 64;
    localparam int CNT_W      = 4;
    localparam int ID_W       = 8;
    localparam int HEAD_IDX_W = 8;
    localparam int STATUS_W   = 8;
    localparam int CODE_W     = 3;
    localparam int SLOT_NUM_W = 7;
    localparam int DEPTH_W    = 8;
    localparam int MEAN_W     = 14;
    localparam int STAT_W     = 64;

    // mean saturates at the top of its field
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    typedef enum logic [1:0] {
        OP_SUBMIT   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_opcode;

    typedef enum logic [CODE_W-1:0] {
        RES_ACCEPTED     = 3'd0,
        RES_BEYOND_CAP   = 3'd1,
        RES_NO_SLOT      = 3'd2,
        RES_HEAD_BUSY    = 3'd3,
        RES_DONE_OK      = 3'd4,
        RES_DONE_IO_ERR  = 3'd5,
        RES_UNKNOWN_HEAD = 3'd6,
        RES_STATS_ACK    = 3'd7
    } t_result;

    // classified command kinds handed from front to back
    typedef enum logic [2:0] {
        KIND_SUBMIT,
        KIND_REJECT,
        KIND_COMPLETE,
        KIND_QUERY,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [ID_W-1:0]       request_id;
        logic [HEAD_IDX_W-1:0] head_index;
        logic                  head_in_range;
        logic                  status_ok;
    } t_cmd;

endpackage

@@ hw/rtl/block_request_tag_tracker.sv @@
// block_request_tag_tracker: top level of the outstanding block request tracker
// depends on brtt_pkg, brtt_front, brtt_queue, brtt_back (with brtt_ram, brtt_div)
//
// usage
//   config channel: one register, the device capacity in sectors, written with
//     i_cfg_valid; o_cfg_ready is always high, so every valid cycle is a transfer
//   input channel: i_in_valid / o_in_stall, one transfer per command (submit,
//     completion, stats query, stats clear); the front checks the sector range
//     and drops the classified command into a two-entry queue
//   output channel: o_out_valid / i_out_stall, exactly one result per command,
//     in command order, held in an output register
//   sequence: a submit, reject, clear or sample-free query is executed in EXEC;
//     a completion also passes HEAD and OWNER (head table then owner table read);
//     a query with samples waits in DIV, where the 64-step serial divider runs
//   the back-end sequencer, with its single-port table reads, takes the next
//     command only after emitting a result; queries are bound by the divider
//   receiver stall: the result waits in the output register, the back-end holds
//     its command, and the queue keeps taking input until it fills, then
//     o_in_stall rises
//   reset: synchronous, active low; all slots free, all heads unbound, count and
//     stats zero, capacity zero; no clearing pass is needed

module block_request_tag_tracker #(
    parameter int SLOTS       = brtt_pkg::SLOTS_DEF,
    parameter int HEADS       = brtt_pkg::HEADS_DEF,
    parameter int MAX_SECTORS = brtt_pkg::MAX_SECTORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brtt_pkg::LBA_W-1:0]      i_cfg_capacity_sectors,
    // command input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [brtt_pkg::ID_W-1:0]       i_request_id,
    input  logic [brtt_pkg::LBA_W-1:0]      i_sector_lba,
    input  logic [brtt_pkg::CNT_W-1:0]      i_sector_count,
    input  logic [brtt_pkg::HEAD_IDX_W-1:0] i_head_index,
    input  logic [brtt_pkg::STATUS_W-1:0]   i_device_status,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [brtt_pkg::CODE_W-1:0]     o_result_code,
    output logic [brtt_pkg::SLOT_NUM_W-1:0] o_slot_number,
    output logic [brtt_pkg::ID_W-1:0]       o_owner_id,
    output logic [brtt_pkg::DEPTH_W-1:0]    o_in_flight,
    output logic [brtt_pkg::DEPTH_W-1:0]    o_depth_max,
    output logic [brtt_pkg::MEAN_W-1:0]     o_mean_depth_x100
);

    brtt_pkg::t_cmd front_cmd;
    brtt_pkg::t_cmd queue_cmd;
    logic           queue_full;
    logic           queue_empty;
    logic           queue_pop;
    logic           in_xfer;

    // the queue being full is the only reason to stall the sender
    assign o_in_stall = queue_full;
    assign in_xfer    = i_in_valid && !queue_full;

    brtt_front #(
        .HEADS       (HEADS),
        .MAX_SECTORS (MAX_SECTORS)
    ) u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_capacity_sectors (i_cfg_capacity_sectors),
        .i_opcode               (i_opcode),
        .i_request_id           (i_request_id),
        .i_sector_lba           (i_sector_lba),
        .i_sector_count         (i_sector_count),
        .i_head_index           (i_head_index),
        .i_device_status        (i_device_status),
        .o_cmd                  (front_cmd)
    );

    // decouples classification from execution
    brtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    // slot/head tables, in-flight count, depth stats and result register
    brtt_back #(
        .SLOTS (SLOTS),
        .HEADS (HEADS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (queue_empty),
        .i_q_cmd           (queue_cmd),
        .o_q_pop           (queue_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_code     (o_result_code),
        .o_slot_number     (o_slot_number),
        .o_owner_id        (o_owner_id),
        .o_in_flight       (o_in_flight),
        .o_depth_max       (o_depth_max),
        .o_mean_depth_x100 (o_mean_depth_x100)
    );

endmodule

@@ hw/rtl/brtt_ram.sv @@
// brtt_ram: generic single-port memory with registered read data
// no dependencies

module brtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/brtt_front.sv @@
// brtt_front: capacity register and classification of incoming items
// depends on brtt_pkg

module brtt_front #(
    parameter int HEADS       = brtt_pkg::HEADS_DEF,
    parameter int MAX_SECTORS = brtt_pkg::MAX_SECTORS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brtt_pkg::LBA_W-1:0]      i_cfg_capacity_sectors,
    input  logic [1:0]                      i_opcode,
    input  logic [brtt_pkg::ID_W-1:0]       i_request_id,
    input  logic [brtt_pkg::LBA_W-1:0]      i_sector_lba,
    input  logic [brtt_pkg::CNT_W-1:0]      i_sector_count,
    input  logic [brtt_pkg::HEAD_IDX_W-1:0] i_head_index,
    input  logic [brtt_pkg::STATUS_W-1:0]   i_device_status,
    output brtt_pkg::t_cmd                  o_cmd
);

    logic [brtt_pkg::LBA_W-1:0] r_capacity;
    logic [brtt_pkg::LBA_W-1:0] end_sector;
    logic                       bad_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_capacity_sectors;
        end
    end

    assign o_cfg_ready = 1'b1;

    // end of transfer wraps at 64 bits
    assign end_sector = i_sector_lba + brtt_pkg::LBA_W'(i_sector_count);
    assign bad_range  = (i_sector_count == '0)
                     || (i_sector_count > brtt_pkg::CNT_W'(MAX_SECTORS))
                     || (end_sector > r_capacity);

    always_comb begin
        o_cmd.request_id    = i_request_id;
        o_cmd.head_index    = i_head_index;
        o_cmd.head_in_range = ({1'b0, i_head_index} < (brtt_pkg::HEAD_IDX_W + 1)'(HEADS));
        o_cmd.status_ok     = (i_device_status == '0);
        unique case (brtt_pkg::t_opcode'(i_opcode))
            brtt_pkg::OP_SUBMIT:   o_cmd.kind = bad_range ? brtt_pkg::KIND_REJECT
                                                          : brtt_pkg::KIND_SUBMIT;
            brtt_pkg::OP_COMPLETE: o_cmd.kind = brtt_pkg::KIND_COMPLETE;
            brtt_pkg::OP_QUERY:    o_cmd.kind = brtt_pkg::KIND_QUERY;
            brtt_pkg::OP_CLEAR:    o_cmd.kind = brtt_pkg::KIND_CLEAR;
            default:               o_cmd.kind = brtt_pkg::KIND_CLEAR;
        endcase
    end

endmodule

@@ hw/rtl/brtt_queue.sv @@
// brtt_queue: two-entry command queue between front and back
// depends on brtt_pkg

module brtt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brtt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output brtt_pkg::t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    brtt_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

@@ hw/rtl/brtt_div.sv @@
// brtt_div: bit-serial divider for the mean depth, one quotient bit per cycle
// depends on brtt_pkg

module brtt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brtt_pkg::STAT_W-1:0] i_sum,
    input  logic [brtt_pkg::STAT_W-1:0] i_samples,
    output logic                        o_busy,
    output logic [brtt_pkg::MEAN_W-1:0] o_mean
);

    localparam int W     = brtt_pkg::STAT_W;
    localparam int STEPS = W;
    localparam int STP_W = $clog2(STEPS);

    logic             r_busy;
    logic [STP_W-1:0] r_step;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_div;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             q_bit;

    // shifted-in remainder and trial subtract
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            // sum times 100 as 64 + 32 + 4, wrapping at 64 bits
            r_quo <= (i_sum << 6) + (i_sum << 5) + (i_sum << 2);
            r_rem <= '0;
            r_div <= i_samples;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], q_bit};
        end
    end

    assign o_busy = r_busy;
    assign o_mean = (|r_quo[W-1:brtt_pkg::MEAN_W]) ? brtt_pkg::MEAN_MAX
                                                   : r_quo[brtt_pkg::MEAN_W-1:0];

endmodule

@@ hw/rtl/brtt_back.sv @@
// brtt_back: executes classified commands against slot and head tables, keeps stats
// depends on brtt_pkg, brtt_ram, brtt_div

module brtt_back #(
    parameter int SLOTS = brtt_pkg::SLOTS_DEF,
    parameter int HEADS = brtt_pkg::HEADS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  brtt_pkg::t_cmd                  i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [brtt_pkg::CODE_W-1:0]     o_result_code,
    output logic [brtt_pkg::SLOT_NUM_W-1:0] o_slot_number,
    output logic [brtt_pkg::ID_W-1:0]       o_owner_id,
    output logic [brtt_pkg::DEPTH_W-1:0]    o_in_flight,
    output logic [brtt_pkg::DEPTH_W-1:0]    o_depth_max,
    output logic [brtt_pkg::MEAN_W-1:0]     o_mean_depth_x100
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HEAD_W = $clog2(HEADS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HEAD,
        S_OWNER,
        S_DIV
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    brtt_pkg::t_cmd                r_cmd;
    logic [SLOT_W-1:0]             r_slot;
    logic [SLOTS-1:0]              r_slot_valid;
    logic [HEADS-1:0]              r_head_valid;
    logic [SLOT_W-1:0]             r_free_slot;
    logic                          r_any_free;
    logic [brtt_pkg::DEPTH_W-1:0]  r_count;
    logic [brtt_pkg::DEPTH_W-1:0]  r_peak;
    logic [brtt_pkg::STAT_W-1:0]   r_sum;
    logic [brtt_pkg::STAT_W-1:0]   r_samples;

    logic                          r_out_valid;
    brtt_pkg::t_result             r_out_code;
    logic [brtt_pkg::SLOT_NUM_W-1:0] r_out_slot;
    logic [brtt_pkg::ID_W-1:0]     r_out_owner;
    logic [brtt_pkg::DEPTH_W-1:0]  r_out_in_flight;
    logic [brtt_pkg::DEPTH_W-1:0]  r_out_peak;
    logic [brtt_pkg::MEAN_W-1:0]   r_out_mean;

    logic [SLOT_W-1:0]             f_slot;
    logic                          f_any;
    logic [HEAD_W-1:0]             head_idx;
    logic                          head_hit;
    logic                          can_emit;
    logic                          do_emit;
    logic                          do_submit;
    logic                          do_complete;
    logic                          do_clear;
    logic                          div_start;
    logic                          div_busy;
    logic [brtt_pkg::MEAN_W-1:0]   div_mean;
    brtt_pkg::t_result             e_code;
    logic [brtt_pkg::SLOT_NUM_W-1:0] e_slot;
    logic [brtt_pkg::ID_W-1:0]     e_owner;
    logic [brtt_pkg::MEAN_W-1:0]   e_mean;
    logic [brtt_pkg::DEPTH_W-1:0]  e_count;
    logic [brtt_pkg::DEPTH_W-1:0]  e_peak;
    logic [brtt_pkg::DEPTH_W-1:0]  count_inc;
    logic [brtt_pkg::DEPTH_W-1:0]  count_dec;
    logic [SLOT_W-1:0]             head_rdata;
    logic [brtt_pkg::ID_W-1:0]     owner_rdata;
    logic [SLOT_W-1:0]             owner_addr;

    assign head_idx = r_cmd.head_index[HEAD_W-1:0];
    assign head_hit = r_cmd.head_in_range && r_head_valid[head_idx];
    assign can_emit = !r_out_valid || !i_out_stall;

    // lowest free slot, registered for the next command
    always_comb begin
        f_any  = 1'b0;
        f_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                f_any  = 1'b1;
                f_slot = SLOT_W'(i);
            end
        end
    end

    assign count_inc = r_count + 1'b1;
    assign count_dec = (r_count != '0) ? (r_count - 1'b1) : r_count;

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        do_emit     = 1'b0;
        do_submit   = 1'b0;
        do_complete = 1'b0;
        do_clear    = 1'b0;
        e_code      = brtt_pkg::RES_STATS_ACK;
        e_slot      = '0;
        e_owner     = '0;
        e_mean      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.kind)
                    brtt_pkg::KIND_REJECT: begin
                        if (can_emit) begin
                            do_emit = 1'b1;
                            e_code  = brtt_pkg::RES_BEYOND_CAP;
                            n_state = S_IDLE;
                        end
                    end
                    brtt_pkg::KIND_SUBMIT: begin
                        if (can_emit) begin
                            do_emit = 1'b1;
                            n_state = S_IDLE;
                            if (!r_any_free) begin
                                e_code = brtt_pkg::RES_NO_SLOT;
                            end else if (!r_cmd.head_in_range) begin
                                e_code = brtt_pkg::RES_UNKNOWN_HEAD;
                            end else if (head_hit) begin
                                e_code = brtt_pkg::RES_HEAD_BUSY;
                            end else begin
                                do_submit = 1'b1;
                                e_code    = brtt_pkg::RES_ACCEPTED;
                                e_slot    = brtt_pkg::SLOT_NUM_W'(r_free_slot);
                                e_owner   = r_cmd.request_id;
                            end
                        end
                    end
                    brtt_pkg::KIND_COMPLETE: begin
                        if (!head_hit) begin
                            if (can_emit) begin
                                do_emit = 1'b1;
                                e_code  = brtt_pkg::RES_UNKNOWN_HEAD;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_HEAD;
                        end
                    end
                    brtt_pkg::KIND_QUERY: begin
                        if (r_samples == '0) begin
                            if (can_emit) begin
                                do_emit = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    brtt_pkg::KIND_CLEAR: begin
                        if (can_emit) begin
                            do_emit  = 1'b1;
                            do_clear = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HEAD: begin
                n_state = S_OWNER;
            end
            S_OWNER: begin
                if (can_emit) begin
                    do_emit     = 1'b1;
                    do_complete = 1'b1;
                    e_code      = r_cmd.status_ok ? brtt_pkg::RES_DONE_OK
                                                  : brtt_pkg::RES_DONE_IO_ERR;
                    e_slot      = brtt_pkg::SLOT_NUM_W'(r_slot);
                    e_owner     = owner_rdata;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                if (!div_busy && can_emit) begin
                    do_emit = 1'b1;
                    e_mean  = div_mean;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // count and peak as seen after this command
    always_comb begin
        e_count = r_count;
        e_peak  = r_peak;
        if (do_submit) begin
            e_count = count_inc;
            if (count_inc > r_peak) begin
                e_peak = count_inc;
            end
        end else if (do_complete) begin
            e_count = count_dec;
        end else if (do_clear) begin
            e_peak = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
            r_head_valid <= '0;
            r_any_free   <= 1'b1;
            r_free_slot  <= '0;
            r_count      <= '0;
            r_peak       <= '0;
            r_sum        <= '0;
            r_samples    <= '0;
        end else begin
            r_state     <= n_state;
            r_any_free  <= f_any;
            r_free_slot <= f_slot;
            r_count     <= e_count;
            r_peak      <= e_peak;
            if (do_submit) begin
                r_slot_valid[r_free_slot] <= 1'b1;
                r_head_valid[head_idx]    <= 1'b1;
                r_sum                     <= r_sum + brtt_pkg::STAT_W'(count_inc);
                r_samples                 <= r_samples + 1'b1;
            end else if (do_complete) begin
                r_slot_valid[r_slot]   <= 1'b0;
                r_head_valid[head_idx] <= 1'b0;
            end else if (do_clear) begin
                r_sum     <= '0;
                r_samples <= '0;
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == S_HEAD) begin
            r_slot <= head_rdata;
        end
        if (do_emit) begin
            r_out_code      <= e_code;
            r_out_slot      <= e_slot;
            r_out_owner     <= e_owner;
            r_out_in_flight <= e_count;
            r_out_peak      <= e_peak;
            r_out_mean      <= e_mean;
        end
    end

    // head entry holds the slot bound to that head
    brtt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (HEADS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (do_submit),
        .i_addr  (head_idx),
        .i_wdata (r_free_slot),
        .o_rdata (head_rdata)
    );

    always_comb begin
        if (r_state == S_HEAD) begin
            owner_addr = head_rdata;
        end else if (r_state == S_OWNER) begin
            owner_addr = r_slot;
        end else begin
            owner_addr = r_free_slot;
        end
    end

    brtt_ram #(
        .WIDTH (brtt_pkg::ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (do_submit),
        .i_addr  (owner_addr),
        .i_wdata (r_cmd.request_id),
        .o_rdata (owner_rdata)
    );

    brtt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sum     (r_sum),
        .i_samples (r_samples),
        .o_busy    (div_busy),
        .o_mean    (div_mean)
    );

    assign o_out_valid       = r_out_valid;
    assign o_result_code     = r_out_code;
    assign o_slot_number     = r_out_slot;
    assign o_owner_id        = r_out_owner;
    assign o_in_flight       = r_out_in_flight;
    assign o_depth_max       = r_out_peak;
    assign o_mean_depth_x100 = r_out_mean;

endmodule

@@ hw/rtl/brtt_checker.sv @@
// brtt_checker: port-level assertions for the request tracker, bound to the top level
// depends on brtt_pkg and block_request_tag_tracker

module brtt_checker #(
    parameter int SLOTS = brtt_pkg::SLOTS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [brtt_pkg::CODE_W-1:0]     o_result_code,
    input logic [brtt_pkg::SLOT_NUM_W-1:0] o_slot_number,
    input logic [brtt_pkg::DEPTH_W-1:0]    o_in_flight,
    input logic [brtt_pkg::MEAN_W-1:0]     o_mean_depth_x100
);

    // a stalled result holds its code and slot
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_code)
                                       && $stable(o_slot_number))
        else $error("stalled result changed");

    // an accepted submit always leaves at least one request in flight
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_code == brtt_pkg::RES_ACCEPTED) |-> o_in_flight != '0)
        else $error("accepted submit with zero in flight");

    // mean is only reported on a stats result
    a_mean_only_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mean_depth_x100 != '0)
            |-> o_result_code == brtt_pkg::RES_STATS_ACK)
        else $error("mean on non-stats result");

    // in-flight count is bounded by the slot count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_flight <= brtt_pkg::DEPTH_W'(SLOTS))
        else $error("in-flight count above slot count");

endmodule

bind block_request_tag_tracker brtt_checker #(
    .SLOTS (SLOTS)
) u_brtt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_result_code     (o_result_code),
    .o_slot_number     (o_slot_number),
    .o_in_flight       (o_in_flight),
    .o_mean_depth_x100 (o_mean_depth_x100)
);

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench of the block request tag tracker
// depends on brtt_pkg and block_request_tag_tracker; needs no files or arguments
`timescale 1ns / 100ps

module tb_top;

    localparam int LBA_W      = brtt_pkg::LBA_W;
    localparam int CNT_W      = brtt_pkg::CNT_W;
    localparam int ID_W       = brtt_pkg::ID_W;
    localparam int HEAD_IDX_W = brtt_pkg::HEAD_IDX_W;
    localparam int STATUS_W   = brtt_pkg::STATUS_W;
    localparam int CODE_W     = brtt_pkg::CODE_W;
    localparam int SLOT_NUM_W = brtt_pkg::SLOT_NUM_W;
    localparam int DEPTH_W    = brtt_pkg::DEPTH_W;
    localparam int MEAN_W     = brtt_pkg::MEAN_W;
    localparam int STAT_W     = brtt_pkg::STAT_W;

    localparam int N_SLOTS    = brtt_pkg::SLOTS_DEF;
    localparam int N_HEADS    = brtt_pkg::HEADS_DEF;
    localparam int N_MAX_SECT = brtt_pkg::MAX_SECTORS_DEF;
    localparam logic [LBA_W-1:0]  LBA_TOP  = '1;
    localparam logic [MEAN_W-1:0] MEAN_SAT = brtt_pkg::MEAN_MAX;

    // one command as presented on the input channel
    typedef struct packed {
        brtt_pkg::t_opcode     op;
        logic [ID_W-1:0]       rid;
        logic [LBA_W-1:0]      lba;
        logic [CNT_W-1:0]      cnt;
        logic [HEAD_IDX_W-1:0] head;
        logic [STATUS_W-1:0]   status;
    } t_tb_cmd;

    // one result as seen on the output channel
    typedef struct packed {
        brtt_pkg::t_result     code;
        logic [SLOT_NUM_W-1:0] slot;
        logic [ID_W-1:0]       owner;
        logic [DEPTH_W-1:0]    in_flight;
        logic [DEPTH_W-1:0]    depth_max;
        logic [MEAN_W-1:0]     mean;
    } t_tb_res;

    typedef enum bit {ROW_CMD, ROW_CFG} t_row_kind;

    // one line of the directed table
    typedef struct {
        t_row_kind        kind;
        logic [LBA_W-1:0] cfg;
        t_tb_cmd          c;
        int               reps;
        bit               typed;
        t_tb_res          want;
    } t_dir_row;

    // dut ports; every input starts at a known value
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [LBA_W-1:0]      i_cfg_capacity_sectors = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_opcode = '0;
    logic [ID_W-1:0]       i_request_id = '0;
    logic [LBA_W-1:0]      i_sector_lba = '0;
    logic [CNT_W-1:0]      i_sector_count = '0;
    logic [HEAD_IDX_W-1:0] i_head_index = '0;
    logic [STATUS_W-1:0]   i_device_status = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CODE_W-1:0]     o_result_code;
    logic [SLOT_NUM_W-1:0] o_slot_number;
    logic [ID_W-1:0]       o_owner_id;
    logic [DEPTH_W-1:0]    o_in_flight;
    logic [DEPTH_W-1:0]    o_depth_max;
    logic [MEAN_W-1:0]     o_mean_depth_x100;

    // tracker state as the testbench sees it
    logic [LBA_W-1:0]      cap_sectors;
    bit                    slot_busy [N_SLOTS];
    logic [ID_W-1:0]       slot_owner_id [N_SLOTS];
    bit                    head_bound [N_HEADS];
    logic [SLOT_NUM_W-1:0] head_slot [N_HEADS];
    logic [DEPTH_W-1:0]    inflight_cnt;
    logic [DEPTH_W-1:0]    peak_cnt;
    logic [STAT_W-1:0]     depth_total;
    logic [STAT_W-1:0]     depth_samples;

    // results owed by the dut, oldest first
    t_tb_res  pending_results [$];
    t_dir_row dir_tab [$];

    int  err_count = 0;
    bit  quiet = 1'b0;   // no idling on either side while set
    int  n_accepted = 0;
    int  n_refused = 0;
    int  n_completed = 0;
    int  n_unknown = 0;
    int  n_stats = 0;
    int  top_inflight = 0;

    block_request_tag_tracker DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_capacity_sectors (i_cfg_capacity_sectors),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_opcode               (i_opcode),
        .i_request_id           (i_request_id),
        .i_sector_lba           (i_sector_lba),
        .i_sector_count         (i_sector_count),
        .i_head_index           (i_head_index),
        .i_device_status        (i_device_status),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_result_code          (o_result_code),
        .o_slot_number          (o_slot_number),
        .o_owner_id             (o_owner_id),
        .o_in_flight            (o_in_flight),
        .o_depth_max            (o_depth_max),
        .o_mean_depth_x100      (o_mean_depth_x100)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the dut hangs
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // works out the result of one command and advances the tracker state
    function automatic t_tb_res track_cmd(t_tb_cmd c);
        t_tb_res           r;
        int                s;
        logic [LBA_W-1:0]  end_lba;
        logic [STAT_W-1:0] q;
        r = '0;
        case (c.op)
            brtt_pkg::OP_SUBMIT: begin
                // sum wraps at 64 bits before the capacity compare
                end_lba = c.lba + {{(LBA_W-CNT_W){1'b0}}, c.cnt};
                s = -1;
                for (int k = 0; k < N_SLOTS; k++)
                    if (s < 0 && !slot_busy[k]) s = k;
                if (c.cnt == 0 || int'(c.cnt) > N_MAX_SECT || end_lba > cap_sectors) begin
                    r.code = brtt_pkg::RES_BEYOND_CAP;
                end else if (s < 0) begin
                    r.code = brtt_pkg::RES_NO_SLOT;
                end else if (int'(c.head) >= N_HEADS) begin
                    r.code = brtt_pkg::RES_UNKNOWN_HEAD;
                end else if (head_bound[c.head]) begin
                    r.code = brtt_pkg::RES_HEAD_BUSY;
                end else begin
                    slot_busy[s] = 1'b1;
                    slot_owner_id[s] = c.rid;
                    head_bound[c.head] = 1'b1;
                    head_slot[c.head] = SLOT_NUM_W'(s);
                    inflight_cnt++;
                    if (inflight_cnt > peak_cnt) peak_cnt = inflight_cnt;
                    depth_total += {{(STAT_W-DEPTH_W){1'b0}}, inflight_cnt};
                    depth_samples++;
                    r.code = brtt_pkg::RES_ACCEPTED;
                    r.slot = SLOT_NUM_W'(s);
                    r.owner = c.rid;
                end
            end
            brtt_pkg::OP_COMPLETE: begin
                if (int'(c.head) >= N_HEADS || !head_bound[c.head]) begin
                    r.code = brtt_pkg::RES_UNKNOWN_HEAD;
                end else begin
                    s = int'(head_slot[c.head]);
                    head_bound[c.head] = 1'b0;
                    head_slot[c.head] = '0;
                    r.slot = SLOT_NUM_W'(s);
                    r.owner = slot_owner_id[s];
                    slot_busy[s] = 1'b0;
                    slot_owner_id[s] = '0;
                    if (inflight_cnt != 0) inflight_cnt--;
                    r.code = (c.status == 0) ? brtt_pkg::RES_DONE_OK
                                             : brtt_pkg::RES_DONE_IO_ERR;
                end
            end
            brtt_pkg::OP_QUERY: begin
                r.code = brtt_pkg::RES_STATS_ACK;
                if (depth_samples != 0) begin
                    // product is taken modulo 2^64, quotient saturates
                    q = (depth_total * 64'd100) / depth_samples;
                    r.mean = (q > {{(STAT_W-MEAN_W){1'b0}}, MEAN_SAT}) ? MEAN_SAT
                                                                       : q[MEAN_W-1:0];
                end
            end
            default: begin
                // stats clear keeps the requests in flight
                peak_cnt = '0;
                depth_total = '0;
                depth_samples = '0;
                r.code = brtt_pkg::RES_STATS_ACK;
            end
        endcase
        r.in_flight = inflight_cnt;
        r.depth_max = peak_cnt;
        return r;
    endfunction

    // a head that is bound right now, or the fallback if none is
    function automatic logic [HEAD_IDX_W-1:0] bound_head_or(logic [HEAD_IDX_W-1:0] fallback);
        int first;
        int idx;
        first = $urandom_range(0, N_HEADS - 1);
        for (int k = 0; k < N_HEADS; k++) begin
            idx = (first + k) % N_HEADS;
            if (head_bound[idx]) return HEAD_IDX_W'(idx);
        end
        return fallback;
    endfunction

    function automatic t_tb_cmd mk_cmd(brtt_pkg::t_opcode op, logic [ID_W-1:0] rid,
                                       logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt,
                                       logic [HEAD_IDX_W-1:0] head,
                                       logic [STATUS_W-1:0] status);
        t_tb_cmd c;
        c.op = op;
        c.rid = rid;
        c.lba = lba;
        c.cnt = cnt;
        c.head = head;
        c.status = status;
        return c;
    endfunction

    // typed expectations never carry a mean
    function automatic t_tb_res mk_res(brtt_pkg::t_result code, logic [SLOT_NUM_W-1:0] slot,
                                       logic [ID_W-1:0] owner, logic [DEPTH_W-1:0] in_flight,
                                       logic [DEPTH_W-1:0] depth_max);
        t_tb_res r;
        r = '0;
        r.code = code;
        r.slot = slot;
        r.owner = owner;
        r.in_flight = in_flight;
        r.depth_max = depth_max;
        return r;
    endfunction

    function automatic void dir_cmd(t_tb_cmd c, int reps);
        dir_tab.push_back('{ROW_CMD, '0, c, reps, 1'b0, t_tb_res'('0)});
    endfunction

    function automatic void dir_chk(t_tb_cmd c, t_tb_res want);
        dir_tab.push_back('{ROW_CMD, '0, c, 1, 1'b1, want});
    endfunction

    function automatic void dir_cfg(logic [LBA_W-1:0] cap);
        dir_tab.push_back('{ROW_CFG, cap, t_tb_cmd'('0), 0, 1'b0, t_tb_res'('0)});
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // input side: random idle cycles, then hold the command until it is taken
    task automatic send_cmd(input t_tb_cmd c, input bit typed, input t_tb_res want);
        t_tb_res predicted;
        bit      taken;
        while (!quiet && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= c.op;
        i_request_id    <= c.rid;
        i_sector_lba    <= c.lba;
        i_sector_count  <= c.cnt;
        i_head_index    <= c.head;
        i_device_status <= c.status;
        // stall is stable between the falling edge and the next rising edge
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        predicted = track_cmd(c);
        pending_results.push_back(typed ? want : predicted);
        case (predicted.code) inside
            brtt_pkg::RES_ACCEPTED: n_accepted++;
            brtt_pkg::RES_BEYOND_CAP, brtt_pkg::RES_NO_SLOT,
            brtt_pkg::RES_HEAD_BUSY: n_refused++;
            brtt_pkg::RES_DONE_OK, brtt_pkg::RES_DONE_IO_ERR: n_completed++;
            brtt_pkg::RES_UNKNOWN_HEAD: n_unknown++;
            default: n_stats++;
        endcase
        if (int'(predicted.in_flight) > top_inflight) top_inflight = int'(predicted.in_flight);
    endtask

    // hold off the input side until every owed result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // capacity is only written with the tracker idle
    task automatic write_capacity(input logic [LBA_W-1:0] cap);
        bit rdy;
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_capacity_sectors <= cap;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        cap_sectors = cap;
    endtask

    // output side: random stall, none during the quiet stretch
    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 15);
    end

    // a result transfer happens at the rising edge after this falling edge
    always @(negedge i_clk) begin : result_check
        t_tb_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no command waiting, result_code %0d", o_result_code);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_code", want.code, o_result_code);
                check_field("slot_number", want.slot, o_slot_number);
                check_field("owner_id", want.owner, o_owner_id);
                check_field("in_flight", want.in_flight, o_in_flight);
                check_field("depth_max", want.depth_max, o_depth_max);
                check_field("mean_depth_x100", want.mean, o_mean_depth_x100);
            end
        end
    end

    initial begin
        t_tb_cmd          c;
        logic [LBA_W-1:0] cap;
        int               sub_w;
        int               pick;
        int               n_items;

        // tracker state after reset
        cap_sectors = '0;
        foreach (slot_busy[k]) begin
            slot_busy[k] = 1'b0;
            slot_owner_id[k] = '0;
        end
        foreach (head_bound[k]) begin
            head_bound[k] = 1'b0;
            head_slot[k] = '0;
        end
        inflight_cnt = '0;
        peak_cnt = '0;
        depth_total = '0;
        depth_samples = '0;

        // directed table: capacity is zero until the first write
        dir_chk(mk_cmd(brtt_pkg::OP_QUERY, 0, 0, 0, 0, 0),
                mk_res(brtt_pkg::RES_STATS_ACK, 0, 0, 0, 0));
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 0, 0, 1, 0, 0),
                mk_res(brtt_pkg::RES_BEYOND_CAP, 0, 0, 0, 0));
        dir_chk(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 0, 0),
                mk_res(brtt_pkg::RES_UNKNOWN_HEAD, 0, 0, 0, 0));
        dir_chk(mk_cmd(brtt_pkg::OP_CLEAR, 0, 0, 0, 0, 0),
                mk_res(brtt_pkg::RES_STATS_ACK, 0, 0, 0, 0));
        dir_cfg(LBA_TOP);
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 8'hFF, 0, 8, 8'hFF, 0),
                mk_res(brtt_pkg::RES_ACCEPTED, 0, 8'hFF, 1, 1));
        // bad sector counts: zero, just above the maximum, all ones
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 1, 0, 0, 1, 0),
                mk_res(brtt_pkg::RES_BEYOND_CAP, 0, 0, 1, 1));
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 1, 0, 9, 1, 0),
                mk_res(brtt_pkg::RES_BEYOND_CAP, 0, 0, 1, 1));
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 1, LBA_TOP, 4'hF, 1, 0),
                mk_res(brtt_pkg::RES_BEYOND_CAP, 0, 0, 1, 1));
        dir_chk(mk_cmd(brtt_pkg::OP_SUBMIT, 1, 5, 1, 8'hFF, 0),
                mk_res(brtt_pkg::RES_HEAD_BUSY, 0, 0, 1, 1));
        // transfers that wrap past, or end at, the top of the address space
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h80, LBA_TOP, 1, 8'h80, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h7F, LBA_TOP - 7, 8, 8'h7F, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h01, LBA_TOP - 1, 1, 8'h01, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1);
        // completions: ok, then the same head again, then error statuses
        dir_cmd(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 8'hFF, 8'h00), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 8'hFF, 8'h00), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 8'h80, 8'hFF), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 8'h7F, 8'h01), 1);
        dir_cfg(64'd100);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h22, 92, 8, 8'h02, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h23, 93, 8, 8'h03, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h24, LBA_TOP - 3, 8, 8'h04, 0), 1);
        // fill every slot, then check the order of the submit checks
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h40, 0, 4, 8'h10, 0), N_SLOTS);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h55, 200, 1, 8'h10, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_SUBMIT, 8'h56, 0, 1, 8'h10, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1);
        dir_cmd(mk_cmd(brtt_pkg::OP_COMPLETE, 0, 0, 0, 8'h01, 8'h55), 1);

        // reset held from the start and released once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_capacity(dir_tab[i].cfg);
            end else begin
                for (int k = 0; k < dir_tab[i].reps; k++) begin
                    c = dir_tab[i].c;
                    c.head += HEAD_IDX_W'(k);
                    c.rid += ID_W'(k);
                    send_cmd(c, dir_tab[i].typed, dir_tab[i].want);
                end
            end
        end

        // random part, one capacity per phase: all ones, small, zero, mid, random
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: cap = LBA_TOP;
                1: cap = 64'd256;
                2: cap = '0;
                3: cap = 64'd4096;
                default: cap = {$urandom, $urandom};
            endcase
            write_capacity(cap);
            n_items = (ph == 2) ? 40 : 140;
            for (int j = 0; j < n_items; j++) begin
                // a long stretch with neither side idling
                quiet = (ph == 1 && j < 90);
                // sender waits for every result once mid-phase
                if (ph == 0 && j == 70) drain_results();

                c.rid = ID_W'($urandom);
                c.lba = {$urandom, $urandom};
                c.cnt = CNT_W'($urandom);
                c.head = HEAD_IDX_W'($urandom);
                c.status = STATUS_W'($urandom);
                // keep the depth moving up and down across the slot range
                sub_w = (inflight_cnt < 12) ? 50 : 25;
                pick = $urandom_range(0, 99);
                if (pick < sub_w) begin
                    c.op = brtt_pkg::OP_SUBMIT;
                    if ($urandom_range(0, 99) < 88) c.cnt = CNT_W'($urandom_range(1, N_MAX_SECT));
                    else c.cnt = CNT_W'($urandom_range(N_MAX_SECT + 1, 16));
                    case ($urandom_range(0, 9)) inside
                        [0:4]: c.lba = (cap > 8) ? {$urandom, $urandom} % (cap - 7) : '0;
                        5: c.lba = cap - {{(LBA_W-CNT_W){1'b0}}, c.cnt}
                                   + LBA_W'($urandom_range(0, 1));
                        6: c.lba = LBA_TOP - LBA_W'($urandom_range(0, 15));
                        default: ;
                    endcase
                    if ($urandom_range(0, 99) < 15) c.head = bound_head_or(c.head);
                end else if (pick < sub_w + 38) begin
                    c.op = brtt_pkg::OP_COMPLETE;
                    if ($urandom_range(0, 99) < 85) c.head = bound_head_or(c.head);
                    if ($urandom_range(0, 1) == 1) c.status = '0;
                end else if (pick < 95) begin
                    c.op = brtt_pkg::OP_QUERY;
                end else begin
                    c.op = brtt_pkg::OP_CLEAR;
                end
                send_cmd(c, 1'b0, t_tb_res'('0));
            end
            quiet = 1'b0;
        end

        // all commands in; wait out the results
        drain_results();
        repeat (80) @(posedge i_clk);

        $display("covered %0d accepted and %0d refused submits, %0d completions,",
                 n_accepted, n_refused, n_completed);
        $display("%0d unknown heads, %0d stats commands, peak in-flight %0d of %0d slots",
                 n_unknown, n_stats, top_inflight, N_SLOTS);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/brtt_pkg.sv
hw/rtl/brtt_ram.sv
hw/rtl/brtt_front.sv
hw/rtl/brtt_queue.sv
hw/rtl/brtt_div.sv
hw/rtl/brtt_back.sv
hw/rtl/block_request_tag_tracker.sv
hw/rtl/brtt_checker.sv
tb/sv/tb_top.sv
